### rtl/core/pskn_pkg.sv
// Shared types and codes for the point store with k-nearest search.
`timescale 1ns / 1ps
package pskn_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 33;
  localparam int unsigned ID_W    = 8;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NEIGHBOR = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

endpackage

### rtl/core/point_store_k_nearest.sv
// Point table with insert-or-find and brute-force k-nearest query.
//
// Usage: one input word per item on the in_ channel. op = insert stores the
// point unless an equal point is present and returns one word with the new or
// existing id (or a full-table status). op = query returns up to want_count
// neighbor words in ascending squared distance, ties to the lower id, with
// out_last on the final one; a query with no neighbor returns one word with
// status none. Results leave on the out_ channel from an output register.
// Timing: the table memory is read one entry per cycle. An insert's word is
// loaded into the output register once the scan pipeline drains (sooner
// when it stops at its first match). A query's first word follows once the
// scan has drained through the read, square and distance registers into the
// sorted list; the further neighbor words follow from the list in order. The
// next item is taken once the last result word of the current one is in the output register.
// A stall on out_ holds the output register and pauses the result phase; the
// scan itself is not held. Reset empties the table (count goes to zero) and
// clears state, valid flags and neighbor list; no memory clearing pass is needed.
`timescale 1ns / 1ps
module point_store_k_nearest #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned MAX_NEAREST = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic signed [15:0]        in_point_x,
  input  logic signed [15:0]        in_point_y,
  input  logic [4:0]                in_want_count,
  input  logic                      in_skip_enable,
  input  logic [7:0]                in_skip_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_entry_id,
  output logic [32:0]               out_sq_distance,
  output logic [2:0]                out_status,
  output logic                      out_last
);

  localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (IW > 8) ? IW : 8;
  localparam int unsigned KW   = $clog2(MAX_NEAREST + 1);
  localparam int unsigned KCW  = (KW > 5) ? KW : 5;
  localparam int unsigned DW   = pskn_pkg::DIST_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE,
    S_EMIT
  } state_t;

  typedef logic [MAX_NEAREST-1:0][DW-1:0] dist_arr_t;
  typedef logic [MAX_NEAREST-1:0][IW-1:0] id_arr_t;

  state_t                   state_r, state_nxt;
  logic                     op_r, op_nxt;
  pskn_pkg::coord_t         q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic                     skip_en_r, skip_en_nxt;
  logic [7:0]               skip_id_r, skip_id_nxt;
  logic [CW-1:0]            rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic [IW-1:0]            id1_r, id1_nxt, id2_r, id2_nxt, id3_r, id3_nxt;
  logic [31:0]              sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  pskn_pkg::dist_t          d_r, d_nxt;
  logic                     found_r, found_nxt;
  logic [IW-1:0]            found_id_r, found_id_nxt;
  logic [MAX_NEAREST-1:0]   slot_val_r, slot_val_nxt;
  dist_arr_t                slot_d_r, slot_d_nxt;
  id_arr_t                  slot_id_r, slot_id_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_id_r, out_id_nxt;
  pskn_pkg::dist_t          out_dist_r, out_dist_nxt;
  logic [2:0]               out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [31:0]              mem [MAX_ENTRIES];
  logic [31:0]              rdata_r;
  logic                     mem_we;

  logic                     in_take;
  logic                     issuing;
  logic                     out_free;
  logic                     out_load;
  logic                     skip_hit;
  logic signed [16:0]       dx, dy;
  logic signed [33:0]       px2, py2;
  logic [MAX_NEAREST-1:0]   slot_en, gt, gt_prev, val_prev, val_shift;
  dist_arr_t                d_prev;
  id_arr_t                  id_prev;
  logic [KCW-1:0]           want_ext;

  function automatic logic [7:0] to_id8(input logic [IW-1:0] v);
    logic [CMPW-1:0] e;
    e = CMPW'(v);
    return e[7:0];
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign issuing  = (state_r == S_SCAN) && (rd_idx_r != count_r) && !found_r;
  assign skip_hit = skip_en_r && (CMPW'(rd_idx_r[IW-1:0]) == CMPW'(skip_id_r));
  assign want_ext = KCW'(in_want_count);

  assign dx  = $signed({rdata_r[15], rdata_r[15:0]});
  assign dy  = $signed({rdata_r[31], rdata_r[31:16]});

  always_comb begin
    logic signed [16:0] qx, qy;
    qx  = $signed({q_x_r[15], q_x_r});
    qy  = $signed({q_y_r[15], q_y_r});
    px2 = (qx - dx) * (qx - dx);
    py2 = (qy - dy) * (qy - dy);
  end

  always_comb begin
    for (int i = 0; i < MAX_NEAREST; i++) begin
      slot_en[i] = (KW'(i) < k_r);
      gt[i] = slot_en[i] && (!slot_val_r[i] || (slot_d_r[i] > d_r));
    end
    gt_prev   = (gt << 1) & slot_en;
    val_prev  = slot_val_r << 1;
    val_shift = slot_val_r >> 1;
    d_prev    = slot_d_r << DW;
    id_prev   = slot_id_r << IW;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    q_x_nxt        = q_x_r;
    q_y_nxt        = q_y_r;
    k_nxt          = k_r;
    skip_en_nxt    = skip_en_r;
    skip_id_nxt    = skip_id_r;
    rd_idx_nxt     = rd_idx_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    found_id_nxt   = found_id_r;
    slot_val_nxt   = slot_val_r;
    slot_d_nxt     = slot_d_r;
    slot_id_nxt    = slot_id_r;
    out_id_nxt     = out_id_r;
    out_dist_nxt   = out_dist_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_load       = 1'b0;
    mem_we         = 1'b0;

    v1_nxt  = issuing && !((op_r == pskn_pkg::OP_QUERY) && skip_hit);
    id1_nxt = rd_idx_r[IW-1:0];
    v2_nxt  = v1_r && (op_r == pskn_pkg::OP_QUERY);
    id2_nxt = id1_r;
    sqx_nxt = px2[31:0];
    sqy_nxt = py2[31:0];
    v3_nxt  = v2_r;
    id3_nxt = id2_r;
    d_nxt   = DW'(sqx_r) + DW'(sqy_r);

    if (issuing) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end

    // The first matching entry in scan order is the lowest matching id.
    if (v1_r && (op_r == pskn_pkg::OP_INSERT) && !found_r
        && (rdata_r == {q_y_r, q_x_r})) begin
      found_nxt    = 1'b1;
      found_id_nxt = id1_r;
    end

    // Insertion into the sorted neighbor list; equal distances go behind.
    if (v3_r) begin
      for (int i = 0; i < MAX_NEAREST; i++) begin
        if (gt[i] && !gt_prev[i]) begin
          slot_d_nxt[i]  = d_r;
          slot_id_nxt[i] = id3_r;
          slot_val_nxt[i] = 1'b1;
        end else if (gt_prev[i]) begin
          slot_d_nxt[i]  = d_prev[i];
          slot_id_nxt[i] = id_prev[i];
          slot_val_nxt[i] = val_prev[i];
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt    = S_SCAN;
          op_nxt       = in_op;
          q_x_nxt      = in_point_x;
          q_y_nxt      = in_point_y;
          k_nxt        = (want_ext > KCW'(MAX_NEAREST)) ? KW'(MAX_NEAREST)
                                                        : KW'(want_ext);
          skip_en_nxt  = in_skip_enable;
          skip_id_nxt  = in_skip_id;
          rd_idx_nxt   = '0;
          found_nxt    = 1'b0;
          slot_val_nxt = '0;
        end
      end
      S_SCAN: begin
        if (!issuing && !v1_r && !v2_r && !v3_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (op_r == pskn_pkg::OP_INSERT) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_dist_nxt = '0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
            if (found_r) begin
              out_id_nxt     = to_id8(found_id_r);
              out_status_nxt = pskn_pkg::ST_PRESENT;
            end else if (count_r == CW'(MAX_ENTRIES)) begin
              out_id_nxt     = '0;
              out_status_nxt = pskn_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              out_id_nxt     = to_id8(count_r[IW-1:0]);
              out_status_nxt = pskn_pkg::ST_NEW;
              count_nxt      = count_r + 1'b1;
            end
          end
        end else if (!slot_val_r[0]) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_id_nxt     = '0;
            out_dist_nxt   = '0;
            out_status_nxt = pskn_pkg::ST_NONE;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_id_nxt     = to_id8(slot_id_r[0]);
          out_dist_nxt   = slot_d_r[0];
          out_status_nxt = pskn_pkg::ST_NEIGHBOR;
          out_last_nxt   = !val_shift[0];
          slot_val_nxt   = val_shift;
          slot_d_nxt     = slot_d_r >> DW;
          slot_id_nxt    = slot_id_r >> IW;
          if (!val_shift[0]) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IW-1:0]] <= {q_y_r, q_x_r};
    end
    rdata_r <= mem[rd_idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      slot_val_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      slot_val_r  <= slot_val_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    q_x_r        <= q_x_nxt;
    q_y_r        <= q_y_nxt;
    k_r          <= k_nxt;
    skip_en_r    <= skip_en_nxt;
    skip_id_r    <= skip_id_nxt;
    rd_idx_r     <= rd_idx_nxt;
    id1_r        <= id1_nxt;
    id2_r        <= id2_nxt;
    id3_r        <= id3_nxt;
    sqx_r        <= sqx_nxt;
    sqy_r        <= sqy_nxt;
    d_r          <= d_nxt;
    found_id_r   <= found_id_nxt;
    slot_d_r     <= slot_d_nxt;
    slot_id_r    <= slot_id_nxt;
    out_id_r     <= out_id_nxt;
    out_dist_r   <= out_dist_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_entry_id    = out_id_r;
  assign out_sq_distance = out_dist_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  // Valid neighbor slots always form a prefix of the list.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((slot_val_r + 1'b1) & slot_val_r) == '0)
    else $error("neighbor slots not contiguous");

  // The scan address never runs past the stored entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= count_r))
    else $error("scan address beyond entry count");

  // A new entry bumps the count by exactly one.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (count_r == $past(count_r) + 1'b1))
    else $error("count not advanced on insert");

endmodule

### test/point_store_k_nearest_tb.sv
// Self-checking testbench for the point store with k-nearest search.
`timescale 1ns / 1ps
module point_store_k_nearest_tb;

  localparam int unsigned MAX_ENTRIES  = 256;
  localparam int unsigned MAX_NEAREST  = 16;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned FULL_ITEMS   = 16;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct {
    pskn_pkg::op_t    op;
    pskn_pkg::coord_t x;
    pskn_pkg::coord_t y;
    logic [4:0]       want;
    logic             skip_en;
    logic [7:0]       skip_id;
  } item_t;

  typedef struct {
    logic [7:0]        id;
    pskn_pkg::dist_t   sq_dist;
    pskn_pkg::status_t status;
    logic              last;
  } word_t;

  class knn_table;
    pskn_pkg::coord_t px [MAX_ENTRIES];
    pskn_pkg::coord_t py [MAX_ENTRIES];
    int unsigned      stored;
    int unsigned      errors;
    word_t            awaited_words [$];

    function void push(logic [7:0] id, pskn_pkg::dist_t sq_dist,
                       pskn_pkg::status_t status, logic last);
      word_t w;
      w.id = id;
      w.sq_dist = sq_dist;
      w.status = status;
      w.last = last;
      awaited_words = {awaited_words, w};
    endfunction

    function void accept_item(item_t it);
      int unsigned     k;
      int unsigned     n;
      int unsigned     pos;
      pskn_pkg::dist_t best_d [MAX_NEAREST];
      int unsigned     best_id [MAX_NEAREST];
      longint          dx;
      longint          dy;
      pskn_pkg::dist_t d;
      if (it.op == pskn_pkg::OP_INSERT) begin
        for (int unsigned i = 0; i < stored; i++) begin
          if (px[i] == it.x && py[i] == it.y) begin
            push(8'(i), '0, pskn_pkg::ST_PRESENT, 1'b1);
            return;
          end
        end
        if (stored >= MAX_ENTRIES) begin
          push(8'd0, '0, pskn_pkg::ST_FULL, 1'b1);
          return;
        end
        px[stored] = it.x;
        py[stored] = it.y;
        push(8'(stored), '0, pskn_pkg::ST_NEW, 1'b1);
        stored++;
        return;
      end
      k = (it.want > MAX_NEAREST) ? MAX_NEAREST : it.want;
      n = 0;
      for (int unsigned i = 0; i < stored && k > 0; i++) begin
        if (it.skip_en && i == it.skip_id) continue;
        dx = longint'($signed(it.x)) - longint'($signed(px[i]));
        dy = longint'($signed(it.y)) - longint'($signed(py[i]));
        d = pskn_pkg::dist_t'(dx * dx + dy * dy);
        if (n == k && d >= best_d[n - 1]) continue;
        pos = (n < k) ? n : k - 1;
        while (pos > 0 && best_d[pos - 1] > d) begin
          best_d[pos] = best_d[pos - 1];
          best_id[pos] = best_id[pos - 1];
          pos--;
        end
        best_d[pos] = d;
        best_id[pos] = i;
        if (n < k) n++;
      end
      if (n == 0) begin
        push(8'd0, '0, pskn_pkg::ST_NONE, 1'b1);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        push(8'(best_id[i]), best_d[i], pskn_pkg::ST_NEIGHBOR, i + 1 == n);
      end
    endfunction

    function void check_word(word_t got);
      word_t exp;
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word id=%0d dist=%0d status=%0d last=%0b", $time,
                 got.id, got.sq_dist, got.status, got.last);
        return;
      end
      exp = awaited_words.pop_front();
      if (got.id !== exp.id || got.sq_dist !== exp.sq_dist || got.status !== exp.status ||
          got.last !== exp.last) begin
        errors++;
        $display("%0t: mismatch expected id=%0d dist=%0d status=%0d last=%0b", $time,
                 exp.id, exp.sq_dist, exp.status, exp.last);
        $display("%0t:          actual   id=%0d dist=%0d status=%0d last=%0b", $time,
                 got.id, got.sq_dist, got.status, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [15:0] in_point_x = '0;
  logic [15:0] in_point_y = '0;
  logic [4:0]  in_want_count = '0;
  logic        in_skip_enable = 1'b0;
  logic [7:0]  in_skip_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_entry_id;
  logic [32:0] out_sq_distance;
  logic [2:0]  out_status;
  logic        out_last;

  knn_table    knn = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned cycles = 0;

  point_store_k_nearest #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_NEAREST(MAX_NEAREST)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_want_count(in_want_count),
    .in_skip_enable(in_skip_enable),
    .in_skip_id(in_skip_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_entry_id(out_entry_id),
    .out_sq_distance(out_sq_distance),
    .out_status(out_status),
    .out_last(out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin : result_watch
    word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.id = out_entry_id;
      got.sq_dist = out_sq_distance;
      got.status = pskn_pkg::status_t'(out_status);
      got.last = out_last;
      knn.check_word(got);
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_word(item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_point_x <= it.x;
    in_point_y <= it.y;
    in_want_count <= it.want;
    in_skip_enable <= it.skip_en;
    in_skip_id <= it.skip_id;
    do @(posedge clk); while (in_stall);
    knn.accept_item(it);
  endtask

  function automatic item_t mk(pskn_pkg::op_t op, int x, int y, int want, bit skip_en,
                               int skip_id);
    item_t it;
    it.op = op;
    it.x = pskn_pkg::coord_t'(x);
    it.y = pskn_pkg::coord_t'(y);
    it.want = 5'(want);
    it.skip_en = skip_en;
    it.skip_id = 8'(skip_id);
    return it;
  endfunction

  function automatic pskn_pkg::coord_t near_origin();
    return pskn_pkg::coord_t'(int'($urandom_range(0, 12)) - 6);
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned id;
    bit          full;
    full = (knn.stored == MAX_ENTRIES);
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.want = 5'($urandom);
    it.skip_en = 1'($urandom);
    it.skip_id = 8'($urandom);
    id = (knn.stored == 0) ? 0 : $urandom_range(0, knn.stored - 1);
    pick = $urandom_range(0, 99);
    if (pick < (full ? 40 : 88)) begin
      it.op = pskn_pkg::OP_INSERT;
      pick = $urandom_range(0, 99);
      if (knn.stored != 0 && pick < (full ? 50 : 5)) begin
        it.x = knn.px[id];
        it.y = knn.py[id];
      end else if (pick < (full ? 60 : 15)) begin
        it.x = near_origin();
        it.y = near_origin();
      end
    end else begin
      it.op = pskn_pkg::OP_QUERY;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        it.x = near_origin();
        it.y = near_origin();
      end else if (pick < 50 && knn.stored != 0) begin
        it.x = knn.px[id];
        it.y = knn.py[id];
      end else if (pick < 60) begin
        it.x = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        it.y = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
      case ($urandom_range(0, 9))
        0: begin
          it.want = 5'd0;
        end
        1: begin
          it.want = 5'($urandom_range(17, 31));
        end
        default: begin
          it.want = 5'($urandom_range(1, 16));
        end
      endcase
      if (knn.stored != 0 && $urandom_range(0, 3) != 0) begin
        it.skip_id = 8'($urandom_range(0, knn.stored - 1));
      end
    end
    return it;
  endfunction

  initial begin
    int unsigned n;
    int unsigned after_full;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 65;

    // Empty table, a lone entry that is skipped, and a repeated insert.
    send_word(mk(pskn_pkg::OP_QUERY, 0, 0, 4, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_INSERT, 0, 0, 31, 1'b1, 255));
    send_word(mk(pskn_pkg::OP_QUERY, 5, 5, 3, 1'b1, 0));
    send_word(mk(pskn_pkg::OP_INSERT, 0, 0, 0, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_INSERT, 32767, 32767, 16, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_INSERT, -32768, -32768, 0, 1'b1, 3));
    // Four points at equal distance from the origin to exercise tie order.
    send_word(mk(pskn_pkg::OP_INSERT, 3, 4, 0, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_INSERT, -3, 4, 0, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_INSERT, 4, -3, 0, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_INSERT, -4, -3, 0, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_QUERY, 0, 0, 16, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_QUERY, -32768, -32768, 31, 1'b1, 2));
    send_word(mk(pskn_pkg::OP_QUERY, 32767, 32767, 1, 1'b1, 1));
    send_word(mk(pskn_pkg::OP_QUERY, 0, 0, 0, 1'b0, 0));
    send_word(mk(pskn_pkg::OP_QUERY, 0, 0, 3, 1'b1, 200));
    send_word(mk(pskn_pkg::OP_QUERY, 0, 0, 2, 1'b1, 0));
    send_word(mk(pskn_pkg::OP_QUERY, 1, 1, 16, 1'b0, 255));

    n = 0;
    after_full = 0;
    while (n < RANDOM_ITEMS || after_full < FULL_ITEMS) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 38;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
      end
      send_word(random_item());
      if (knn.stored == MAX_ENTRIES) after_full++;
      n++;
    end
    @(negedge clk) in_valid <= 1'b0;

    while (knn.awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (knn.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pskn_pkg.sv
rtl/core/point_store_k_nearest.sv
test/point_store_k_nearest_tb.sv
